// File: hw/rtl/tpq_pkg.sv
// Package for the time ordered priority queue.
// Holds field widths, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package tpq_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int TAG_W       = 16;
    localparam int KEY_W       = HOUR_W + MIN_W;
    localparam int ENTRY_W     = KEY_W + TAG_W;
    localparam int COUNT_OUT_W = 5;
    localparam int PROC_W      = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 56;
    localparam int M_USED_W    = ENTRY_W + 1 + COUNT_OUT_W + PROC_W;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/tpq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/time_ordered_priority_queue.sv
// Top level of the time ordered priority queue.
// Depends on tpq_pkg and tpq_ram.
`default_nettype none

// Bounded queue of up to CAPACITY entries {hour, minute, tag} kept sorted by
// time, earliest first, in a circular buffer in one RAM. A remove reads the
// head slot and advances the head pointer. An insert walks from the tail
// toward the head, one RAM read and one write per stored entry that is not
// earlier than the new one, moving each up by a slot; it stops at the head
// slot or at an earlier entry, and moves at most CAPACITY - 1 entries. A full
// insert or an empty remove goes straight to the result state. The one RAM
// read port is shared by removes and the insert walk. One request is worked
// on at a time; the result register lets the next request in while a result
// waits.
module time_ordered_priority_queue #(
    parameter int CAPACITY = tpq_pkg::DEFAULT_CAPACITY
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [4:0] entry_hour, [10:5] entry_minute, [26:11] entry_tag
    input  wire  [tpq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  wire                             s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [4:0] out_hour, [10:5] out_minute, [26:11] out_tag, [27] queue_empty,
    // [32:28] entry_count, [48:33] processed_count
    output logic [tpq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [1:0]                      m_axis_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int EW = tpq_pkg::ENTRY_W;
    localparam int KW = tpq_pkg::KEY_W;
    localparam int TW = tpq_pkg::TAG_W;
    localparam int PW = tpq_pkg::PROC_W;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(ofs);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    tpq_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_proc, n_proc;
    logic             r_m_valid, n_m_valid;
    logic [CW-1:0]    r_idx, n_idx;
    logic [EW-1:0]    r_new, n_new;
    logic [EW-1:0]    r_res, n_res;
    tpq_pkg::t_status r_status, n_status;
    logic [tpq_pkg::M_TDATA_W-1:0] r_m_data, n_m_data;
    logic [1:0]       r_m_user, n_m_user;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic             accept;

    tpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == tpq_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_proc    = r_proc;
        n_m_valid = r_m_valid;
        n_idx     = r_idx;
        n_new     = r_new;
        n_res     = r_res;
        n_status  = r_status;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        ram_we    = 1'b0;
        ram_waddr = f_phys(r_head, r_idx);
        ram_wdata = r_new;
        ram_raddr = r_head;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            tpq_pkg::S_IDLE: begin
                if (accept) begin
                    // stored as {hour, minute, tag}: time key in the top bits
                    n_new    = {s_axis_tdata[4:0], s_axis_tdata[10:5],
                                s_axis_tdata[26:11]};
                    n_res    = '0;
                    n_idx    = r_count;
                    n_status = tpq_pkg::ST_OK;
                    if (s_axis_tuser == tpq_pkg::OP_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = tpq_pkg::ST_FULL;
                            n_state  = tpq_pkg::S_DONE;
                        end else begin
                            n_state = tpq_pkg::S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = tpq_pkg::ST_EMPTY;
                            n_state  = tpq_pkg::S_DONE;
                        end else begin
                            n_state = tpq_pkg::S_REM_CMP;
                        end
                    end
                end
            end
            tpq_pkg::S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = tpq_pkg::S_DONE;
                end else begin
                    ram_raddr = f_phys(r_head, r_idx - 1'b1);
                    n_state   = tpq_pkg::S_INS_CMP;
                end
            end
            tpq_pkg::S_INS_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata[EW-1 -: KW] >= r_new[EW-1 -: KW]) begin
                    // shift the entry that is not earlier up one slot and keep walking
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - 1'b1;
                    n_state   = tpq_pkg::S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = tpq_pkg::S_DONE;
                end
            end
            tpq_pkg::S_REM_CMP: begin
                n_res   = ram_rdata;
                n_head  = f_phys(r_head, CW'(1));
                n_count = r_count - 1'b1;
                if (r_proc != '1) begin
                    n_proc = r_proc + 1'b1;
                end
                n_state = tpq_pkg::S_DONE;
            end
            tpq_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_status;
                    n_m_data  = tpq_pkg::M_TDATA_W'({
                        r_proc,
                        tpq_pkg::COUNT_OUT_W'(r_count),
                        (r_count == '0),
                        r_res[TW-1:0],
                        r_res[TW +: tpq_pkg::MIN_W],
                        r_res[EW-1 -: tpq_pkg::HOUR_W]
                    });
                    n_state   = tpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpq_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_proc    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_proc    <= n_proc;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_res    <= n_res;
        r_status <= n_status;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

`default_nettype wire
